FILE: src/pvi_pkg.sv
// shared constants and coefficient table for the profile volume integrator
package pvi_pkg;

	localparam int MAX_SAMPLES = 64;
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

	localparam int ECHO_W  = 16;
	localparam int REG_W   = 21;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;
	localparam int VOL_W   = 32;
	localparam int SAMP_W  = 7;

	localparam int RAD_W   = 24;
	localparam int MUL_W   = 25;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int SUM_W   = 48;
	localparam int DVD_W   = 50;
	localparam int REM_W   = 16;
	localparam int QUO_W   = 34;

	localparam logic [REG_W-1:0] STOP_RESET  = REG_W'(20000);
	localparam logic [REG_W-1:0] WIDTH_RESET = REG_W'(20000);

	localparam logic ADDR_STOP  = 1'b0;
	localparam logic ADDR_WIDTH = 1'b1;

	localparam logic [4:0]  ECHO_SCALE = 5'd17;
	localparam logic [17:0] PI_Q16     = 18'd205887;
	localparam logic [REM_W-1:0] VOL_HALF = REM_W'(15625);
	localparam logic [PROD_W-1:0] ROUND_Q16 = PROD_W'(32768);

	// 2^24 = 536 * 31250 + 27216
	localparam logic [14:0] FOLD_REM  = 15'd27216;
	// ceil(2^37 / 15625), exact for dividends below 2^23
	localparam logic [23:0] RECIP_Q37 = 24'd8796094;

	localparam logic [1:0] CF_A = 2'd0;
	localparam logic [1:0] CF_B = 2'd1;
	localparam logic [1:0] CF_C = 2'd2;

	// Q16 height fractions 25/59, 50/59, 75/59
	function automatic logic [16:0] coef_q16(logic [1:0] k);
		logic [16:0] c;
		case (k)
			CF_A:    c = 17'd27769;
			CF_B:    c = 17'd55539;
			CF_C:    c = 17'd83308;
			default: c = 17'd0;
		endcase
		return c;
	endfunction

endpackage

FILE: src/profile_volume_integrator.sv
// profile volume integrator: echo pairs in, volume and sample count out
//
// input channel: echo_left, echo_right with in_valid / in_stall; a transfer
// happens at a clock edge with in_valid high and in_stall low.
// output channel: volume, samples_taken with out_valid / out_stall, held in
// an output register, so the next item is taken while a result waits.
// config: APB-style write of stop_distance (0x0) and chamber_width (0x4).
// an item whose right distance reaches stop_distance ends the run: it passes
// ST_CHECK and ST_EMIT, and out_valid rises once ST_EMIT finds the output
// register free. the first radius of a run passes only ST_CHECK and ST_STORE;
// each later radius runs one shared 25x25 multiplier through 9 products, then
// divides by 31250 by folding the upper 24 bits (ST_RED then ST_FOLD per fold,
// at most 4 folds) and one reciprocal product; in_stall stays high for the item.
// reaching the sample limit passes through the emit step and clears the run as a stop.
// if out_stall holds a result, a new result waits in the emit step.
// reset clears the run and out_valid (volume and samples_taken are not reset) and sets both registers to 20000.
module profile_volume_integrator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [pvi_pkg::ECHO_W-1:0]  echo_left,
	input  logic [pvi_pkg::ECHO_W-1:0]  echo_right,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [pvi_pkg::VOL_W-1:0]   volume,
	output logic [pvi_pkg::SAMP_W-1:0]  samples_taken,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pvi_pkg::ADDR_W-1:0]  paddr,
	input  logic [pvi_pkg::DATA_W-1:0]  pwdata,
	output logic [pvi_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL_R0,
		ST_ACC_R0,
		ST_MUL_D,
		ST_INTERP,
		ST_MUL_SQ,
		ST_ACC_SQ,
		ST_MUL_PH,
		ST_ACC_PH,
		ST_MUL_PL,
		ST_ACC_PL,
		ST_RED,
		ST_FOLD,
		ST_QUO,
		ST_ADD,
		ST_STORE,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [pvi_pkg::REG_W-1:0]       stop_q;
	logic [pvi_pkg::REG_W-1:0]       width_q;
	logic [pvi_pkg::REG_W-1:0]       dl_q;
	logic [pvi_pkg::REG_W-1:0]       dr_q;
	logic signed [pvi_pkg::RAD_W-1:0] prev_q;
	logic signed [pvi_pkg::MUL_W-1:0] rnew_q;
	logic signed [pvi_pkg::MUL_W-1:0] diff_q;
	logic signed [pvi_pkg::MUL_W-1:0] ri_q;
	logic signed [pvi_pkg::PROD_W-1:0] prod_q;
	logic [pvi_pkg::SUM_W-1:0]       s_q;
	logic [pvi_pkg::DVD_W-1:0]       a_q;
	logic [pvi_pkg::DVD_W-1:0]       dvd_q;
	logic [pvi_pkg::QUO_W-1:0]       quo_q;
	logic [1:0]                      k_q;
	logic [pvi_pkg::CNT_W-1:0]       count_q;
	logic [pvi_pkg::SUM_W-1:0]       sum_q;
	logic                            out_valid_q;
	logic [pvi_pkg::VOL_W-1:0]       volume_q;
	logic [pvi_pkg::SAMP_W-1:0]      samples_q;

	logic                            cfg_wr;
	logic                            in_xfer;
	logic                            out_free;
	logic signed [pvi_pkg::MUL_W-1:0] mul_a;
	logic signed [pvi_pkg::MUL_W-1:0] mul_b;
	logic signed [pvi_pkg::PROD_W-1:0] mul_p;
	logic signed [pvi_pkg::PROD_W-1:0] rnd;
	logic [pvi_pkg::SUM_W-1:0]       sq_term;
	logic                            fold_done;
	logic [pvi_pkg::QUO_W-1:0]       fold_quo;
	logic [pvi_pkg::SUM_W:0]         sum_next;
	logic [pvi_pkg::CNT_W-1:0]       count_inc;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign prdata   = (paddr[2] == pvi_pkg::ADDR_STOP) ?
		pvi_pkg::DATA_W'(stop_q) : pvi_pkg::DATA_W'(width_q);

	assign in_stall      = (state_q != ST_IDLE);
	assign in_xfer       = in_valid && !in_stall;
	assign out_valid     = out_valid_q;
	assign volume        = volume_q;
	assign samples_taken = samples_q;
	assign out_free      = !out_valid_q || !out_stall;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL_R0: begin
				mul_a = pvi_pkg::MUL_W'(prev_q);
				mul_b = pvi_pkg::MUL_W'(prev_q);
			end
			ST_MUL_D: begin
				mul_a = diff_q;
				mul_b = $signed(pvi_pkg::MUL_W'(pvi_pkg::coef_q16(k_q)));
			end
			ST_MUL_SQ: begin
				mul_a = ri_q;
				mul_b = ri_q;
			end
			ST_MUL_PH: begin
				mul_a = $signed(pvi_pkg::MUL_W'(s_q[47:24]));
				mul_b = $signed(pvi_pkg::MUL_W'(pvi_pkg::PI_Q16));
			end
			ST_MUL_PL: begin
				mul_a = $signed(pvi_pkg::MUL_W'(s_q[23:0]));
				mul_b = $signed(pvi_pkg::MUL_W'(pvi_pkg::PI_Q16));
			end
			ST_RED: begin
				if (fold_done) begin
					mul_a = $signed(pvi_pkg::MUL_W'(dvd_q[23:1]));
					mul_b = $signed(pvi_pkg::MUL_W'(pvi_pkg::RECIP_Q37));
				end else begin
					mul_a = $signed(pvi_pkg::MUL_W'(dvd_q[47:24]));
					mul_b = $signed(pvi_pkg::MUL_W'(pvi_pkg::FOLD_REM));
				end
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p     = mul_a * mul_b;
	assign rnd       = prod_q + $signed(pvi_pkg::ROUND_Q16);
	assign sq_term   = (k_q != pvi_pkg::CF_C) ? {prod_q[46:0], 1'b0} : prod_q[47:0];
	assign fold_done = (dvd_q[pvi_pkg::DVD_W-1:24] == '0);
	// upper part times 536
	assign fold_quo  = pvi_pkg::QUO_W'({dvd_q[47:24], 9'b0})
		+ pvi_pkg::QUO_W'({dvd_q[47:24], 4'b0})
		+ pvi_pkg::QUO_W'({dvd_q[47:24], 3'b0});
	assign sum_next  = {1'b0, sum_q} + (pvi_pkg::SUM_W + 1)'(quo_q);
	assign count_inc = count_q + pvi_pkg::CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q  <= pvi_pkg::STOP_RESET;
			width_q <= pvi_pkg::WIDTH_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == pvi_pkg::ADDR_STOP) begin
				stop_q <= pwdata[pvi_pkg::REG_W-1:0];
			end else begin
				width_q <= pwdata[pvi_pkg::REG_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_q      <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						dl_q    <= pvi_pkg::REG_W'(echo_left) * pvi_pkg::REG_W'(pvi_pkg::ECHO_SCALE);
						dr_q    <= pvi_pkg::REG_W'(echo_right) * pvi_pkg::REG_W'(pvi_pkg::ECHO_SCALE);
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					rnew_q <= $signed(pvi_pkg::MUL_W'(width_q)) - $signed(pvi_pkg::MUL_W'(dl_q))
						- $signed(pvi_pkg::MUL_W'(dr_q));
					if (dr_q >= stop_q) begin
						state_q <= ST_EMIT;
					end else if (count_q == '0) begin
						state_q <= ST_STORE;
					end else begin
						state_q <= ST_MUL_R0;
					end
				end
				ST_MUL_R0: begin
					prod_q  <= mul_p;
					diff_q  <= rnew_q - pvi_pkg::MUL_W'(prev_q);
					k_q     <= pvi_pkg::CF_A;
					state_q <= ST_ACC_R0;
				end
				ST_ACC_R0: begin
					s_q     <= prod_q[47:0];
					state_q <= ST_MUL_D;
				end
				ST_MUL_D: begin
					prod_q  <= mul_p;
					state_q <= ST_INTERP;
				end
				ST_INTERP: begin
					ri_q    <= pvi_pkg::MUL_W'(prev_q) + $signed(rnd[40:16]);
					state_q <= ST_MUL_SQ;
				end
				ST_MUL_SQ: begin
					prod_q  <= mul_p;
					state_q <= ST_ACC_SQ;
				end
				ST_ACC_SQ: begin
					s_q <= s_q + sq_term;
					if (k_q == pvi_pkg::CF_C) begin
						state_q <= ST_MUL_PH;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_MUL_D;
					end
				end
				ST_MUL_PH: begin
					prod_q  <= mul_p;
					state_q <= ST_ACC_PH;
				end
				ST_ACC_PH: begin
					a_q     <= {prod_q[41:0], 8'b0};
					state_q <= ST_MUL_PL;
				end
				ST_MUL_PL: begin
					prod_q  <= mul_p;
					state_q <= ST_ACC_PL;
				end
				ST_ACC_PL: begin
					dvd_q   <= a_q + pvi_pkg::DVD_W'(prod_q[49:16])
						+ pvi_pkg::DVD_W'(pvi_pkg::VOL_HALF);
					quo_q   <= '0;
					state_q <= ST_RED;
				end
				ST_RED: begin
					prod_q <= mul_p;
					if (fold_done) begin
						state_q <= ST_QUO;
					end else begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					dvd_q   <= prod_q[pvi_pkg::DVD_W-1:0] + pvi_pkg::DVD_W'(dvd_q[23:0]);
					quo_q   <= quo_q + fold_quo;
					state_q <= ST_RED;
				end
				ST_QUO: begin
					quo_q   <= quo_q + pvi_pkg::QUO_W'(prod_q[49:37]);
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					// saturate the running sum
					sum_q   <= sum_next[pvi_pkg::SUM_W] ? '1 : sum_next[pvi_pkg::SUM_W-1:0];
					state_q <= ST_STORE;
				end
				ST_STORE: begin
					prev_q  <= rnew_q[pvi_pkg::RAD_W-1:0];
					count_q <= count_inc;
					if (count_inc >= pvi_pkg::CNT_W'(pvi_pkg::MAX_SAMPLES)) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						volume_q    <= (sum_q[pvi_pkg::SUM_W-1:pvi_pkg::VOL_W] != '0) ?
							'1 : sum_q[pvi_pkg::VOL_W-1:0];
						samples_q   <= pvi_pkg::SAMP_W'(count_q);
						prev_q      <= '0;
						count_q     <= '0;
						sum_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
